### src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/sed_pkg.sv
// Package with the types and constants of the star edit distance block.
`timescale 1ns / 1ps
package sed_pkg;

   localparam int MAX_LEAVES_DEF  = 64;
   localparam int LABEL_BITS_DEF  = 16;
   localparam int LABEL_PORT_BITS = 16;
   localparam int DIST_BITS       = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_WALK,
      ST_REPORT
   } sed_state_type;

   typedef struct packed {
      logic load;
      logic prime;
      logic step;
      logic finish;
   } sed_cmd_type;

   typedef struct packed {
      logic walk_done;
   } sed_status_type;

endpackage

### src/star_edit_distance_top.sv
// Top level of the star edit distance block: controller and datapath.
// A word without the last mark is taken in the idle state and busy stays low.
// After a last word the controller goes through prime, the merge walk
// (one step per cycle) and the strobing report state.
// busy falls in the cycle after the strobe; the receiver cannot stall the result.
// Synchronous reset clears counts, roots, the error flag and the controller.
`timescale 1ns / 1ps
module star_edit_distance_top #(
   parameter int MAX_LEAVES = sed_pkg::MAX_LEAVES_DEF,
   parameter int LABEL_BITS = sed_pkg::LABEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_side,
   input  logic                                req_is_root,
   input  logic [sed_pkg::LABEL_PORT_BITS-1:0] req_label,
   input  logic                                req_last,
   output logic                                rsp_strobe,
   output logic [sed_pkg::DIST_BITS-1:0]       rsp_distance,
   output logic                                rsp_order_error
);
   import sed_pkg::*;

   sed_cmd_type    cmd;
   sed_status_type status;

   sed_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_start  (start),
      .req_last   (req_last),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   sed_datapath #(
      .MAX_LEAVES (MAX_LEAVES),
      .LABEL_BITS (LABEL_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_side        (req_side),
      .req_is_root     (req_is_root),
      .req_label       (req_label),
      .rsp_distance    (rsp_distance),
      .rsp_order_error (rsp_order_error)
   );

endmodule

### src/sed_controller.sv
// Controller state machine that sequences loading, the merge walk and the result.
`timescale 1ns / 1ps
module sed_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_start,
   input  logic                    req_last,
   input  sed_pkg::sed_status_type status,
   output sed_pkg::sed_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);
   import sed_pkg::*;

   sed_state_type state_ff;
   sed_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_start && req_last) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = req_start;
         end
         ST_PRIME: begin
            cmd.prime = 1'b1;
         end
         ST_WALK: begin
            cmd.step   = !status.walk_done;
            cmd.finish = status.walk_done;
         end
         ST_REPORT: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

### src/sed_datapath.sv
// Datapath with the leaf stores, the merge walk counters and the distance arithmetic.
`timescale 1ns / 1ps
module sed_datapath #(
   parameter int MAX_LEAVES = sed_pkg::MAX_LEAVES_DEF,
   parameter int LABEL_BITS = sed_pkg::LABEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sed_pkg::sed_cmd_type                cmd,
   output sed_pkg::sed_status_type             status,
   input  logic                                req_side,
   input  logic                                req_is_root,
   input  logic [sed_pkg::LABEL_PORT_BITS-1:0] req_label,
   output logic [sed_pkg::DIST_BITS-1:0]       rsp_distance,
   output logic                                rsp_order_error
);
   import sed_pkg::*;

   localparam int STORE_BITS = (LABEL_BITS < LABEL_PORT_BITS) ? LABEL_BITS : LABEL_PORT_BITS;
   localparam int CNT_BITS   = $clog2(MAX_LEAVES + 1);
   localparam int IDX_BITS   = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
   localparam int SUM_BITS   = CNT_BITS + 2;

   logic [STORE_BITS-1:0] store1 [MAX_LEAVES];
   logic [STORE_BITS-1:0] store2 [MAX_LEAVES];

   logic [STORE_BITS-1:0] lab;
   logic [CNT_BITS-1:0]   cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic [STORE_BITS-1:0] root1_ff, root1_in, root2_ff, root2_in;
   logic [STORE_BITS-1:0] prev1_ff, prev1_in, prev2_ff, prev2_in;
   logic                  err_ff, err_in;
   logic [CNT_BITS-1:0]   i_ff, i_in, j_ff, j_in, hits_ff, hits_in;
   logic [STORE_BITS-1:0] rd1_ff, rd2_ff;
   logic [DIST_BITS-1:0]  dist_ff, dist_in;
   logic                  oerr_ff;
   logic                  we1, we2, full1, full2;
   logic [CNT_BITS-1:0]   big, diff;
   logic [SUM_BITS-1:0]   sum;

   assign lab   = req_label[STORE_BITS-1:0];
   assign full1 = (cnt1_ff == CNT_BITS'(MAX_LEAVES));
   assign full2 = (cnt2_ff == CNT_BITS'(MAX_LEAVES));

   always_comb begin
      cnt1_in  = cnt1_ff;
      cnt2_in  = cnt2_ff;
      root1_in = root1_ff;
      root2_in = root2_ff;
      prev1_in = prev1_ff;
      prev2_in = prev2_ff;
      err_in   = err_ff;
      we1      = 1'b0;
      we2      = 1'b0;
      if (cmd.load) begin
         if (req_is_root) begin
            if (req_side) begin
               root2_in = lab;
            end else begin
               root1_in = lab;
            end
         end else if (req_side) begin
            if ((cnt2_ff != '0 && lab < prev2_ff) || full2) begin
               err_in = 1'b1;
            end
            if (!full2) begin
               we2      = 1'b1;
               cnt2_in  = cnt2_ff + CNT_BITS'(1);
               prev2_in = lab;
            end
         end else begin
            if ((cnt1_ff != '0 && lab < prev1_ff) || full1) begin
               err_in = 1'b1;
            end
            if (!full1) begin
               we1      = 1'b1;
               cnt1_in  = cnt1_ff + CNT_BITS'(1);
               prev1_in = lab;
            end
         end
      end
      if (cmd.finish) begin
         cnt1_in  = '0;
         cnt2_in  = '0;
         root1_in = '0;
         root2_in = '0;
         err_in   = 1'b0;
      end
   end

   assign status.walk_done = !((i_ff < cnt1_ff) && (j_ff < cnt2_ff));

   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      hits_in = hits_ff;
      if (cmd.prime) begin
         i_in    = '0;
         j_in    = '0;
         hits_in = '0;
      end else if (cmd.step) begin
         if (rd1_ff < rd2_ff) begin
            i_in = i_ff + CNT_BITS'(1);
         end else if (rd2_ff < rd1_ff) begin
            j_in = j_ff + CNT_BITS'(1);
         end else begin
            i_in    = i_ff + CNT_BITS'(1);
            j_in    = j_ff + CNT_BITS'(1);
            hits_in = hits_ff + CNT_BITS'(1);
         end
      end
   end

   always_comb begin
      big  = (cnt1_ff > cnt2_ff) ? cnt1_ff : cnt2_ff;
      diff = (cnt1_ff > cnt2_ff) ? (cnt1_ff - cnt2_ff) : (cnt2_ff - cnt1_ff);
      sum  = SUM_BITS'(root1_ff != root2_ff) + SUM_BITS'(diff) + SUM_BITS'(big)
             - SUM_BITS'(hits_ff);
      if (32'(sum) > 32'd255) begin
         dist_in = '1;
      end else begin
         dist_in = DIST_BITS'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         store1[cnt1_ff[IDX_BITS-1:0]] <= lab;
      end
      rd1_ff <= store1[i_in[IDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (we2) begin
         store2[cnt2_ff[IDX_BITS-1:0]] <= lab;
      end
      rd2_ff <= store2[j_in[IDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt1_ff  <= '0;
         cnt2_ff  <= '0;
         root1_ff <= '0;
         root2_ff <= '0;
         err_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         hits_ff  <= '0;
      end else begin
         cnt1_ff  <= cnt1_in;
         cnt2_ff  <= cnt2_in;
         root1_ff <= root1_in;
         root2_ff <= root2_in;
         err_ff   <= err_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         hits_ff  <= hits_in;
      end
   end

   always_ff @(posedge clock) begin
      prev1_ff <= prev1_in;
      prev2_ff <= prev2_in;
      if (cmd.finish) begin
         dist_ff <= dist_in;
         oerr_ff <= err_ff;
      end
   end

   assign rsp_distance    = dist_ff;
   assign rsp_order_error = oerr_ff;

endmodule

### src/sed_checker.sv
// Port-level checker for the star edit distance block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sed_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last,
   input logic rsp_strobe
);

   `CHK_SAME(a_strobe_busy, clock, reset, rsp_strobe, busy, "Result word shown while idle.")
   `CHK_NEXT(a_last_busy, clock, reset, start && !busy && req_last, busy && !rsp_strobe, "No walk after last word.")
   `CHK_NEXT(a_plain_idle, clock, reset, start && !busy && !req_last, !busy && !rsp_strobe, "Plain word did not return to idle.")
   `CHK_NEXT(a_strobe_pulse, clock, reset, rsp_strobe, !rsp_strobe && !busy, "Result strobe longer than one cycle.")

endmodule

bind star_edit_distance_top sed_checker u_sed_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_last   (req_last),
   .rsp_strobe (rsp_strobe)
);

### bench/star_edit_distance_top_tb.sv
// Self-checking testbench of the star edit distance block with its scoreboard.
`timescale 1ns / 1ps
module star_edit_distance_top_tb;

   localparam int DEPTH      = sed_pkg::MAX_LEAVES_DEF;
   localparam int LBITS      = sed_pkg::LABEL_PORT_BITS;
   localparam int DBITS      = sed_pkg::DIST_BITS;
   localparam int ITEM_GOAL  = 700;
   localparam int QUIET_MAX  = 2000;
   localparam bit SIDE_FIRST  = 1'b0;
   localparam bit SIDE_SECOND = 1'b1;

   typedef struct {
      bit              side;
      bit              is_root;
      logic [LBITS-1:0] label;
      bit              last;
   } star_word_type;

   typedef struct {
      logic [DBITS-1:0] distance;
      logic             order_error;
   } star_result_type;

   class distance_checker;
      logic [LBITS-1:0] leaves [2][DEPTH];
      int unsigned      count [2];
      logic [LBITS-1:0] root [2];
      bit               err_flag;
      star_result_type  expected_q [$];
      int unsigned      failures;

      function new();
         failures = 0;
         clear_pair();
      endfunction

      function void clear_pair();
         count[0] = 0;
         count[1] = 0;
         root[0] = '0;
         root[1] = '0;
         err_flag = 1'b0;
      endfunction

      function int unsigned common_leaves();
         int unsigned i, j, hits;
         i = 0;
         j = 0;
         hits = 0;
         while (i < count[0] && j < count[1]) begin
            if (leaves[0][i] < leaves[1][j]) begin
               i++;
            end else if (leaves[1][j] < leaves[0][i]) begin
               j++;
            end else begin
               hits++;
               i++;
               j++;
            end
         end
         return hits;
      endfunction

      function void note_word(star_word_type w);
         int unsigned s, big, diff, dist_val;
         star_result_type r;
         s = w.side;
         if (w.is_root) begin
            root[s] = w.label;
         end else begin
            if (count[s] > 0 && w.label < leaves[s][count[s] - 1])
               err_flag = 1'b1;
            if (count[s] >= DEPTH) begin
               err_flag = 1'b1;
            end else begin
               leaves[s][count[s]] = w.label;
               count[s]++;
            end
         end
         if (w.last) begin
            big  = (count[0] > count[1]) ? count[0] : count[1];
            diff = (count[0] > count[1]) ? count[0] - count[1] : count[1] - count[0];
            dist_val = ((root[0] != root[1]) ? 1 : 0) + diff + (big - common_leaves());
            if (dist_val > 255)
               dist_val = 255;
            r.distance = dist_val[DBITS-1:0];
            r.order_error = err_flag;
            expected_q = {expected_q, r};
            clear_pair();
         end
      endfunction

      function void check_distance(logic [DBITS-1:0] d, logic e);
         star_result_type r;
         if (expected_q.size() == 0) begin
            $error("unexpected result: distance %0d order_error %0d", d, e);
            failures++;
            return;
         end
         r = expected_q.pop_front();
         if (d !== r.distance) begin
            $error("distance: expected %0d, actual %0d", r.distance, d);
            failures++;
         end
         if (e !== r.order_error) begin
            $error("order_error: expected %0d, actual %0d", r.order_error, e);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_side;
   logic             req_is_root;
   logic [LBITS-1:0] req_label;
   logic             req_last;
   logic             rsp_strobe;
   logic [DBITS-1:0] rsp_distance;
   logic             rsp_order_error;

   distance_checker sb;
   int unsigned     items_sent;
   int unsigned     quiet_cycles;
   int unsigned     pair_index;

   star_edit_distance_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_side        (req_side),
      .req_is_root     (req_is_root),
      .req_label       (req_label),
      .req_last        (req_last),
      .rsp_strobe      (rsp_strobe),
      .rsp_distance    (rsp_distance),
      .rsp_order_error (rsp_order_error)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_distance(rsp_distance, rsp_order_error);
         if (rsp_strobe || (start && !busy))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_MAX) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_word(input star_word_type w, input int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start       <= 1'b1;
      req_side    <= w.side;
      req_is_root <= w.is_root;
      req_label   <= w.label;
      req_last    <= w.last;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_word(w);
      items_sent++;
   endtask

   task automatic send_list(ref star_word_type words [$], input bit no_idle);
      foreach (words[k])
         send_word(words[k], no_idle ? 0 : $urandom_range(0, 5));
   endtask

   function automatic star_word_type make_word(bit side, bit is_root, int unsigned label,
                                               bit last);
      star_word_type w;
      w.side = side;
      w.is_root = is_root;
      w.label = label[LBITS-1:0];
      w.last = last;
      return w;
   endfunction

   function automatic logic [LBITS-1:0] pick_label(bit narrow);
      return narrow ? LBITS'($urandom_range(0, 15)) : LBITS'($urandom_range(0, 65535));
   endfunction

   task automatic run_pair(input int unsigned n0, input int unsigned n1);
      logic [LBITS-1:0] lv [2][$];
      star_word_type    per_side [2][$];
      star_word_type    words [$];
      star_word_type    w;
      logic [LBITS-1:0] r0;
      bit               narrow, sorted, mix, no_idle;
      int unsigned      s, n [2];
      narrow  = ($urandom_range(0, 1) == 1);
      sorted  = ($urandom_range(0, 9) < 8);
      mix     = !sorted && ($urandom_range(0, 1) == 1);
      no_idle = ($urandom_range(0, 3) == 0);
      n[0] = n0;
      n[1] = n1;
      for (int k = 0; k < n[0]; k++)
         lv[0] = {lv[0], pick_label(narrow)};
      for (int k = 0; k < n[1]; k++) begin
         if (n[0] > 0 && $urandom_range(0, 1) == 1)
            lv[1] = {lv[1], lv[0][$urandom_range(0, n[0] - 1)]};
         else
            lv[1] = {lv[1], pick_label(narrow)};
      end
      r0 = pick_label(narrow);
      for (s = 0; s < 2; s++) begin
         if (sorted)
            lv[s].sort();
         if ($urandom_range(0, 9) != 0)
            per_side[s] = {per_side[s], make_word(s, 1'b1,
               ($urandom_range(0, 1) == 1) ? r0 : pick_label(narrow), 1'b0)};
         foreach (lv[s][k])
            per_side[s] = {per_side[s], make_word(s, 1'b0, lv[s][k], 1'b0)};
         if ($urandom_range(0, 9) == 0)
            per_side[s] = {per_side[s], make_word(s, 1'b1, pick_label(narrow), 1'b0)};
      end
      while (per_side[0].size() > 0 || per_side[1].size() > 0) begin
         if (per_side[1].size() == 0)
            s = SIDE_FIRST;
         else if (per_side[0].size() == 0)
            s = SIDE_SECOND;
         else
            s = $urandom_range(0, 1);
         w = per_side[s].pop_front();
         words = {words, w};
      end
      if (mix)
         words.shuffle();
      if (words.size() == 0)
         words = {words, make_word($urandom_range(0, 1), 1'b1, pick_label(narrow), 1'b0)};
      words[words.size() - 1].last = 1'b1;
      send_list(words, no_idle);
   endtask

   task automatic run_directed();
      star_word_type words [$];
      // Extreme labels, differing roots, last on a leaf.
      words = {words, make_word(SIDE_FIRST,  1'b1, 0,     1'b0)};
      words = {words, make_word(SIDE_SECOND, 1'b1, 65535, 1'b0)};
      words = {words, make_word(SIDE_FIRST,  1'b0, 0,     1'b0)};
      words = {words, make_word(SIDE_FIRST,  1'b0, 65535, 1'b0)};
      words = {words, make_word(SIDE_SECOND, 1'b0, 65535, 1'b1)};
      // A pair of a single leaf word, with both roots missing.
      words = {words, make_word(SIDE_SECOND, 1'b0, 5, 1'b1)};
      // A repeated root that ends the pair.
      words = {words, make_word(SIDE_FIRST,  1'b1, 7, 1'b0)};
      words = {words, make_word(SIDE_SECOND, 1'b1, 9, 1'b0)};
      words = {words, make_word(SIDE_FIRST,  1'b0, 3, 1'b0)};
      words = {words, make_word(SIDE_SECOND, 1'b0, 3, 1'b0)};
      words = {words, make_word(SIDE_SECOND, 1'b1, 7, 1'b1)};
      // Descending leaves on the first side.
      words = {words, make_word(SIDE_FIRST,  1'b0, 10, 1'b0)};
      words = {words, make_word(SIDE_FIRST,  1'b0, 4,  1'b0)};
      words = {words, make_word(SIDE_SECOND, 1'b0, 4,  1'b0)};
      words = {words, make_word(SIDE_SECOND, 1'b0, 10, 1'b1)};
      // A pair of a single root word.
      words = {words, make_word(SIDE_FIRST, 1'b1, 1, 1'b1)};
      // Equal leaves on both sides, repeated on the first side, equal roots.
      words = {words, make_word(SIDE_SECOND, 1'b1, 65535, 1'b0)};
      words = {words, make_word(SIDE_FIRST,  1'b1, 65535, 1'b0)};
      words = {words, make_word(SIDE_FIRST,  1'b0, 2, 1'b0)};
      words = {words, make_word(SIDE_FIRST,  1'b0, 2, 1'b0)};
      words = {words, make_word(SIDE_SECOND, 1'b0, 2, 1'b1)};
      send_list(words, 1'b0);
   endtask

   initial begin
      sb = new();
      items_sent   = 0;
      quiet_cycles = 0;
      pair_index   = 0;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_side    <= 1'b0;
      req_is_root <= 1'b0;
      req_label   <= '0;
      req_last    <= 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      while (items_sent < ITEM_GOAL) begin
         // Full and overflowing stores on three pairs; mostly small stars.
         if (pair_index == 5)
            run_pair(DEPTH, $urandom_range(0, 4));
         else if (pair_index == 20)
            run_pair($urandom_range(0, 4), DEPTH + $urandom_range(1, 4));
         else if (pair_index == 35)
            run_pair(DEPTH + 2, DEPTH);
         else if ($urandom_range(0, 29) == 0)
            run_pair($urandom_range(0, DEPTH + 4), $urandom_range(0, DEPTH + 4));
         else if ($urandom_range(0, 5) == 0)
            run_pair($urandom_range(0, 20), $urandom_range(0, 20));
         else
            run_pair($urandom_range(0, 8), $urandom_range(0, 8));
         pair_index++;
      end
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### star_edit_distance_top.f
+incdir+src
src/sed_pkg.sv
src/sed_controller.sv
src/sed_datapath.sv
src/star_edit_distance_top.sv
src/sed_checker.sv
bench/star_edit_distance_top_tb.sv
